>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands: same-cycle and next-cycle implication under reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SXG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SXG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/sxg_pkg.sv
// ----------------------------------------------------------------------------
// sxg_pkg
// widths, reset values, codes and control types of the xorshift128+ generator
// ----------------------------------------------------------------------------
package sxg_pkg;

   localparam int WORD_W    = 64;
   localparam int LEN_W     = 16;
   localparam int WARM_W    = 8;
   localparam int CMD_W     = 2;
   localparam int BYTES_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int WORD_BYTES = WORD_W / 8;

   localparam int SHIFT_A = 23;
   localparam int SHIFT_B = 17;
   localparam int SHIFT_C = 26;

   localparam logic [WORD_W-1:0]  WORD_A_RESET     = 64'h0000_0000_1000_0000;
   localparam logic [WORD_W-1:0]  WORD_B_RESET     = 64'h0000_0000_FFFF_FFFF;
   localparam logic [BYTES_W-1:0] SEED_BYTES_RESET = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW     = 2'd0,
      CMD_LEN_SEED = 2'd1,
      CMD_SEED     = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_WORD0 = 2'd0,
      CSR_SEED_WORD1 = 2'd1,
      CSR_SEED_BYTES = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_WARM
   } state_type;

   typedef struct packed {
      logic load_key;
      logic set_len;
      logic step;
      logic push;
   } dp_cmd_type;

endpackage

>>> rtl/core/sxg_if.sv
// ----------------------------------------------------------------------------
// sxg_if
// valid/ready channels of the generator: request items and result items
// ----------------------------------------------------------------------------
interface sxg_req_if;
   logic                        valid;
   logic                        ready;
   logic [sxg_pkg::CMD_W-1:0]   cmd;
   logic [sxg_pkg::LEN_W-1:0]   data_length;
   logic [sxg_pkg::WARM_W-1:0]  warm_count;

   modport source (output valid, cmd, data_length, warm_count, input ready);
   modport sink   (input valid, cmd, data_length, warm_count, output ready);
endinterface

interface sxg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sxg_pkg::WORD_W-1:0]  value;

   modport source (output valid, value, input ready);
   modport sink   (input valid, value, output ready);
endinterface

>>> rtl/core/sxg_ctrl.sv
// ----------------------------------------------------------------------------
// sxg_ctrl
// controller: accepts items, decodes commands, counts warm-up steps
// ----------------------------------------------------------------------------
module sxg_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [sxg_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sxg_pkg::WARM_W-1:0]  req_warm_count,
   input  logic                        q_full,
   output logic                        req_ready,
   output sxg_pkg::dp_cmd_type         dp_cmd
);
   import sxg_pkg::*;

   state_type         state_ff, state_in;
   logic [WARM_W-1:0] cnt_ff, cnt_in;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE) && !q_full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_cmd == CMD_LEN_SEED) && (req_warm_count != '0)) begin
               state_in = ST_WARM;
               cnt_in   = req_warm_count;
            end
         end
         ST_WARM: begin
            cnt_in = cnt_ff - WARM_W'(1);
            if (cnt_ff == WARM_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      dp_cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_DRAW: begin
                     dp_cmd.step = 1'b1;
                     dp_cmd.push = 1'b1;
                  end
                  CMD_LEN_SEED: begin
                     dp_cmd.load_key = 1'b1;
                     dp_cmd.set_len  = 1'b1;
                  end
                  CMD_SEED: begin
                     dp_cmd.load_key = 1'b1;
                  end
                  default: begin
                     dp_cmd = '0;
                  end
               endcase
            end
         end
         ST_WARM: begin
            // silent step, result dropped
            dp_cmd.step = 1'b1;
         end
         default: begin
            dp_cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/core/sxg_dp.sv
// ----------------------------------------------------------------------------
// sxg_dp
// datapath: seed registers, state words and the xorshift128+ step
// ----------------------------------------------------------------------------
module sxg_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sxg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sxg_pkg::WORD_W-1:0]     csr_wdata,
   input  sxg_pkg::dp_cmd_type            dp_cmd,
   input  logic [sxg_pkg::LEN_W-1:0]      req_data_length,
   output logic [sxg_pkg::WORD_W-1:0]     draw_value
);
   import sxg_pkg::*;

   logic [WORD_W-1:0]  seed_word0_ff;
   logic [WORD_W-1:0]  seed_word1_ff;
   logic [BYTES_W-1:0] seed_bytes_ff;
   logic [WORD_W-1:0]  word_a_ff, word_a_in;
   logic [WORD_W-1:0]  word_b_ff, word_b_in;
   logic [WORD_W-1:0]  key_a, key_b, seed_a;
   logic [WORD_W-1:0]  mix, step_b;

   // key bytes at or past the byte count read as zero; counts above 16 keep all
   always_comb begin
      for (int i = 0; i < WORD_BYTES; i++) begin
         key_a[8*i +: 8] = (seed_bytes_ff > BYTES_W'(i)) ? seed_word0_ff[8*i +: 8] : 8'h00;
         key_b[8*i +: 8] = (seed_bytes_ff > BYTES_W'(i + WORD_BYTES)) ?
                           seed_word1_ff[8*i +: 8] : 8'h00;
      end
   end

   assign seed_a = dp_cmd.set_len ? {key_a[WORD_W-1:LEN_W], req_data_length} : key_a;

   assign mix        = word_a_ff ^ (word_a_ff << SHIFT_A);
   assign step_b     = mix ^ word_b_ff ^ (mix >> SHIFT_B) ^ (word_b_ff >> SHIFT_C);
   assign draw_value = step_b + word_b_ff;

   always_comb begin
      word_a_in = word_a_ff;
      word_b_in = word_b_ff;
      if (dp_cmd.load_key) begin
         word_a_in = seed_a;
         word_b_in = key_b;
      end else if (dp_cmd.step) begin
         word_a_in = word_b_ff;
         word_b_in = step_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_word0_ff <= '0;
         seed_word1_ff <= '0;
         seed_bytes_ff <= SEED_BYTES_RESET;
         word_a_ff     <= WORD_A_RESET;
         word_b_ff     <= WORD_B_RESET;
      end else begin
         word_a_ff <= word_a_in;
         word_b_ff <= word_b_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SEED_WORD0: seed_word0_ff <= csr_wdata;
               CSR_SEED_WORD1: seed_word1_ff <= csr_wdata;
               CSR_SEED_BYTES: seed_bytes_ff <= csr_wdata[BYTES_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

>>> rtl/core/sxg_outq.sv
// ----------------------------------------------------------------------------
// sxg_outq
// two-entry result queue between the datapath and the result channel
// ----------------------------------------------------------------------------
module sxg_outq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [sxg_pkg::WORD_W-1:0]  push_value,
   output logic                        full,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sxg_pkg::WORD_W-1:0]  rsp_value
);
   import sxg_pkg::*;

   logic [WORD_W-1:0] data_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_value = data_ff[rd_ptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_value;
      end
   end

endmodule

>>> rtl/core/seeded_xorshift128plus_generator.sv
// ----------------------------------------------------------------------------
// seeded_xorshift128plus_generator
// xorshift128+ generator (shifts 23, 17, 26) with key seeding and warm-up
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries commands: draw, seed with length and warm-up, plain seed.
//   rsp_if carries one 64-bit value for each draw; seeds give no item.
//   csr_we/csr_index/csr_wdata write seed_word0, seed_word1 and seed_bytes;
//   write them only while the block is idle.
// Timing and throughput:
//   a draw's value enters the result queue when the draw is accepted and is on
//   rsp_if the cycle after unless earlier values still wait; draws stream at
//   one per cycle while the queue has room. a length seed runs its warm-up steps
//   one per cycle through the single xorshift step unit, with req_if.ready low.
// Reset:
//   synchronous; state words return to 0x10000000 / 0xFFFFFFFF, seed words
//   to zero, seed_bytes to 16, and the result queue empties.
// Stalls:
//   results wait in a two-entry queue; with one waiting, items are still
//   taken, and the queue drops ready only when both entries are full.
// ----------------------------------------------------------------------------
module seeded_xorshift128plus_generator (
   input  logic                           clock,
   input  logic                           reset,
   sxg_req_if.sink                        req_if,
   sxg_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [sxg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sxg_pkg::WORD_W-1:0]     csr_wdata
);
   import sxg_pkg::*;

   dp_cmd_type        dp_cmd;
   logic              q_full;
   logic              ready;
   logic [WORD_W-1:0] draw_value;

   assign req_if.ready = ready;

   sxg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_cmd        (req_if.cmd),
      .req_warm_count (req_if.warm_count),
      .q_full         (q_full),
      .req_ready      (ready),
      .dp_cmd         (dp_cmd)
   );

   sxg_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .dp_cmd          (dp_cmd),
      .req_data_length (req_if.data_length),
      .draw_value      (draw_value)
   );

   sxg_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (dp_cmd.push),
      .push_value (draw_value),
      .full       (q_full),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_value  (rsp_if.value)
   );

endmodule

>>> rtl/core/sxg_checker.sv
// ----------------------------------------------------------------------------
// sxg_checker
// port-level checks of the generator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sxg_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [sxg_pkg::CMD_W-1:0]   req_cmd,
   input logic [sxg_pkg::WARM_W-1:0]  req_warm_count,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sxg_pkg::WORD_W-1:0]  rsp_value
);
   import sxg_pkg::*;

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   `SXG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "stalled result item changed or dropped")
   `SXG_ASSERT_NXT(a_warm_busy, clock, reset, req_acc && (req_cmd == CMD_LEN_SEED) && (req_warm_count != '0), !req_ready, "ready during warm-up")
   `SXG_ASSERT_NXT(a_seed_silent, clock, reset, req_acc && (req_cmd != CMD_DRAW) && !rsp_valid, !rsp_valid, "non-draw item produced a result")
   `SXG_ASSERT_NXT(a_draw_result, clock, reset, req_acc && (req_cmd == CMD_DRAW) && !rsp_valid, rsp_valid, "draw item gave no result")

endmodule

bind seeded_xorshift128plus_generator sxg_checker u_sxg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_cmd        (req_if.cmd),
   .req_warm_count (req_if.warm_count),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_value      (rsp_if.value)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the seeded xorshift128+ generator: a directed table
// of commands, then phases of random commands under different keys, byte
// counts and handshake idling, every drawn value checked in order against a
// table value or a bit-accurate model of the two state words kept in the bench
// ----------------------------------------------------------------------------
module tb;
   import sxg_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES   = 300;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int NUM_PHASES      = 7;
   localparam int N_DIRECTED      = 18;
   localparam int HOLD_CYCLES     = 80;
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [LEN_W-1:0]  len;
      logic [WARM_W-1:0] warm;
      bit                known;
      logic [WORD_W-1:0] value;
   } stim_row_t;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;

   sxg_req_if req_ch ();
   sxg_rsp_if rsp_ch ();

   seeded_xorshift128plus_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model of the generator
   logic [WORD_W-1:0]  gen_word_a;
   logic [WORD_W-1:0]  gen_word_b;
   logic [WORD_W-1:0]  key_word0;
   logic [WORD_W-1:0]  key_word1;
   logic [BYTES_W-1:0] key_bytes;

   logic [WORD_W-1:0] pending_values [$];

   bit                row_known;
   logic [WORD_W-1:0] row_value;
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;
   int n_checked      = 0;
   int n_draws        = 0;
   int n_len_seeds    = 0;
   int n_plain_seeds  = 0;
   int n_ignored      = 0;

   int bytes_tab [NUM_PHASES] = '{16, 0, 31, 1, 9, 8, 17};

   stim_row_t directed_rows [N_DIRECTED] = '{
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b1, 64'h0008_0005_EFFF_F7BF}, // reset state
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b0, '0},
      '{CMD_UNUSED,   16'hFFFF, 8'hFF, 1'b0, '0},  // ignored, state kept
      '{CMD_DRAW,     16'hFFFF, 8'hFF, 1'b0, '0},
      '{CMD_SEED,     16'h0000, 8'h00, 1'b0, '0},  // zero key clears both words
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b1, 64'h0},
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b1, 64'h0},
      '{CMD_LEN_SEED, 16'hFFFF, 8'h00, 1'b0, '0},  // no warm-up, load only
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b0, '0},
      '{CMD_LEN_SEED, 16'h0000, 8'h00, 1'b0, '0},
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b1, 64'h0},
      '{CMD_LEN_SEED, 16'hFFFF, 8'hFF, 1'b0, '0},  // longest warm-up
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b0, '0},
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b0, '0},
      '{CMD_LEN_SEED, 16'h8001, 8'h01, 1'b0, '0},
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b0, '0},
      '{CMD_SEED,     16'hFFFF, 8'hFF, 1'b0, '0},  // length and count unused here
      '{CMD_DRAW,     16'h0000, 8'h00, 1'b1, 64'h0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d values outstanding",
                  cycle_count, pending_values.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [WORD_W-1:0] xorshift_step();
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      x = gen_word_a;
      y = gen_word_b;
      gen_word_a = y;
      x = x ^ (x << SHIFT_A);
      x = x ^ y ^ (x >> SHIFT_B) ^ (y >> SHIFT_C);
      gen_word_b = x;
      return x + y;
   endfunction

   function automatic logic [WORD_W-1:0] keep_bytes(input int n);
      if (n >= WORD_BYTES)
         return '1;
      return (64'd1 << (n * 8)) - 64'd1;
   endfunction

   function automatic void load_key_words();
      int n;
      int n_hi;
      n = (key_bytes > 2 * WORD_BYTES) ? 2 * WORD_BYTES : int'(key_bytes);
      n_hi = (n > WORD_BYTES) ? n - WORD_BYTES : 0;
      gen_word_a = key_word0 & keep_bytes(n);
      gen_word_b = key_word1 & keep_bytes(n_hi);
   endfunction

   task automatic report(input string what, input logic [WORD_W-1:0] expected,
                         input logic [WORD_W-1:0] actual);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected %h, got %h", $realtime, what, expected, actual);
   endtask

   // watches both channels and the register port at each rising edge
   always @(posedge clock) begin
      logic [WORD_W-1:0] drawn;
      logic [WORD_W-1:0] expected;
      if (reset) begin
         gen_word_a = WORD_A_RESET;
         gen_word_b = WORD_B_RESET;
         key_word0  = '0;
         key_word1  = '0;
         key_bytes  = SEED_BYTES_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEED_WORD0: key_word0 = csr_wdata;
               CSR_SEED_WORD1: key_word1 = csr_wdata;
               CSR_SEED_BYTES: key_bytes = csr_wdata[BYTES_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.cmd)
               CMD_DRAW: begin
                  drawn = xorshift_step();
                  pending_values.push_back(row_known ? row_value : drawn);
                  n_draws++;
               end
               CMD_LEN_SEED: begin
                  load_key_words();
                  gen_word_a[LEN_W-1:0] = req_ch.data_length;
                  for (int i = 0; i < int'(req_ch.warm_count); i++)
                     void'(xorshift_step());
                  n_len_seeds++;
               end
               CMD_SEED: begin
                  load_key_words();
                  n_plain_seeds++;
               end
               default: n_ignored++;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_values.size() == 0) begin
               report("value with no draw waiting", 'x, rsp_ch.value);
            end else begin
               expected = pending_values.pop_front();
               n_checked++;
               if (rsp_ch.value !== expected)
                  report("value mismatch", expected, rsp_ch.value);
            end
         end
      end
   end

   // result side: random stalls, plus a long hold-off when asked
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // entered and left at a falling edge
   task automatic offer(input stim_row_t row);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= row.cmd;
      req_ch.data_length <= row.len;
      req_ch.warm_count  <= row.warm;
      row_known = row.known;
      row_value = row.value;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready))
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [WORD_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // a length seed with a long warm-up gives no item, so wait it out too
   task automatic settle();
      while (pending_values.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      stim_row_t         row;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      int                pick;
      int                sent;

      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= CSR_SEED_WORD0;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_DRAW;
      req_ch.data_length <= '0;
      req_ch.warm_count  <= '0;
      row_known = 1'b0;
      row_value = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         offer(directed_rows[i]);
      req_ch.valid <= 1'b0;
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            1: begin
               w0 = '1;
               w1 = '1;
            end
            5: begin
               w0 = '0;
               w1 = '0;
            end
            default: begin
               w0 = {$urandom, $urandom};
               w1 = {$urandom, $urandom};
            end
         endcase
         write_reg(CSR_SEED_WORD0, w0);
         write_reg(CSR_SEED_WORD1, w1);
         write_reg(CSR_SEED_BYTES, WORD_W'(bytes_tab[p]));
         csr_we <= 1'b0;

         case (p % 4)
            0: begin
               src_idle_pct   = 0;
               sink_stall_pct = 0;
               hold_left      = HOLD_CYCLES;
            end
            1: begin
               src_idle_pct   = 69;
               sink_stall_pct = 0;
            end
            2: begin
               src_idle_pct   = 0;
               sink_stall_pct = 69;
            end
            default: begin
               src_idle_pct   = 18;
               sink_stall_pct = 18;
            end
         endcase

         // mostly draws between reseeds; unused codes do not count
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            row.cmd = (pick < 70) ? CMD_DRAW :
                      (pick < 82) ? CMD_LEN_SEED :
                      (pick < 92) ? CMD_SEED : CMD_UNUSED;
            row.len   = LEN_W'($urandom);
            row.warm  = ($urandom_range(7) == 0) ? WARM_W'($urandom)
                                                 : WARM_W'($urandom_range(15));
            row.known = 1'b0;
            row.value = '0;
            offer(row);
            if (row.cmd != CMD_UNUSED)
               sent++;
         end
         req_ch.valid <= 1'b0;
         settle();
      end

      if (pending_values.size() != 0)
         mismatch_count += pending_values.size();

      $display("covered %0d draws, %0d length seeds, %0d plain seeds, %0d unused codes",
               n_draws, n_len_seeds, n_plain_seeds, n_ignored);
      $display("%0d values checked over %0d key settings, %0d mismatches",
               n_checked, NUM_PHASES + 1, mismatch_count);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/sxg_pkg.sv
rtl/core/sxg_if.sv
rtl/core/sxg_ctrl.sv
rtl/core/sxg_dp.sv
rtl/core/sxg_outq.sv
rtl/core/seeded_xorshift128plus_generator.sv
rtl/core/sxg_checker.sv
tb/tb.sv
